/* rtl/core/irb_pkg.sv */
// Shared types and constants for the bilinear / nearest image resizer.
// No dependencies; used by irb_front, irb_back and the top level.
package irb_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int POS_BITS   = 33;
   localparam int STEP_BITS  = 25;
   localparam int SIZE_BITS  = 9;
   localparam int MAX_SIZE   = 256;
   localparam int QDEPTH     = 4;
   localparam int ODEPTH     = 8;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   localparam logic MODE_BILINEAR = 1'b0;
   localparam logic MODE_NEAREST  = 1'b1;

   localparam logic [2:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_X_STEP     = 3'd2;
   localparam logic [2:0] CSR_Y_STEP     = 3'd3;
   localparam logic [2:0] CSR_MODE       = 3'd4;

   typedef struct packed {
      logic                cmd;
      logic [7:0]          cx;
      logic [7:0]          cy;
      logic [7:0]          pix;
      logic [POS_BITS-1:0] posx;
      logic [POS_BITS-1:0] posy;
   } qitem_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
      logic                 mode;
   } cfg_type;

   typedef struct packed {
      logic [2:0] inflight;
      logic [3:0] ocount;
   } stat_type;

endpackage

/* rtl/core/irb_front.sv */
// Front end: accepts requests, maps coordinates to source positions with the
// step multipliers and holds them in a short queue. Depends on irb_pkg.
module irb_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_cmd,
   input  logic [7:0]                       req_coord_x,
   input  logic [7:0]                       req_coord_y,
   input  logic [7:0]                       req_pixel_in,
   input  logic [irb_pkg::STEP_BITS-1:0]    x_step,
   input  logic [irb_pkg::STEP_BITS-1:0]    y_step,
   input  logic                             q_pop,
   output logic                             q_empty,
   output irb_pkg::qitem_type               q_head
);

   irb_pkg::qitem_type q_ff [irb_pkg::QDEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic push, pop;
   irb_pkg::qitem_type item;

   assign req_full = (cnt_ff == 3'(irb_pkg::QDEPTH));
   assign q_empty  = (cnt_ff == 3'd0);
   assign push     = req_push && !req_full;
   assign pop      = q_pop && !q_empty;
   assign q_head   = q_ff[rd_ptr_ff];

   always_comb begin
      item.cmd  = req_cmd;
      item.cx   = req_coord_x;
      item.cy   = req_coord_y;
      item.pix  = req_pixel_in;
      item.posx = {25'd0, req_coord_x} * {8'd0, x_step};
      item.posy = {25'd0, req_coord_y} * {8'd0, y_step};
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      cnt_in    = cnt_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* rtl/core/irb_back.sv */
// Back end: index clamping, four parity-banked frame store memories, the
// blend pipeline and the result queue. Depends on irb_pkg.
module irb_back (
   input  logic                clock,
   input  logic                reset,
   input  irb_pkg::cfg_type    cfg,
   input  logic                q_empty,
   input  irb_pkg::qitem_type  q_head,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_pixel_out,
   output logic [7:0]          rsp_out_x,
   output logic [7:0]          rsp_out_y,
   output irb_pkg::stat_type   stat
);

   // Stage 1: mapped indices and weights.
   logic       s1_v_ff, s1_cmd_ff;
   logic [7:0] s1_x0_ff, s1_x1_ff, s1_y0_ff, s1_y1_ff, s1_fx_ff, s1_fy_ff;
   logic [7:0] s1_cx_ff, s1_cy_ff, s1_pix_ff;
   logic [7:0] x0_in, x1_in, y0_in, y1_in, fx_in, fy_in, wm1, hm1;

   // Stage 2: memory read data.
   logic       s2_v_ff;
   logic [7:0] rd_ff [4];
   logic [1:0] s2_par_ff [4];
   logic [7:0] s2_fx_ff, s2_fy_ff, s2_cx_ff, s2_cy_ff;

   // Stage 3: horizontal blend.
   logic        s3_v_ff;
   logic [16:0] s3_top_ff, s3_bot_ff;
   logic [7:0]  s3_near_ff, s3_fy_ff, s3_cx_ff, s3_cy_ff;

   // Stage 4: final result.
   logic       s4_v_ff;
   logic [7:0] s4_pix_ff, s4_cx_ff, s4_cy_ff;

   logic [23:0] o_ff [irb_pkg::ODEPTH];
   logic [2:0]  owr_ff, ord_ff;
   logic [3:0]  ocnt_ff, ocnt_in;
   logic [2:0]  inflight;
   logic        opop;

   assign inflight = 3'(s1_v_ff && s1_cmd_ff) + 3'(s2_v_ff) + 3'(s3_v_ff) + 3'(s4_v_ff);
   assign q_pop = !q_empty && ({1'b0, inflight} + ocnt_ff < 4'(irb_pkg::ODEPTH));
   assign stat.inflight = inflight;
   assign stat.ocount   = ocnt_ff;

   always_comb begin
      wm1 = 8'(cfg.w - 9'd1);
      hm1 = 8'(cfg.h - 9'd1);
      if (q_head.posx[32:16] >= {8'd0, cfg.w}) begin
         x0_in = wm1;
         fx_in = 8'd0;
      end else begin
         x0_in = q_head.posx[23:16];
         fx_in = q_head.posx[15:8];
      end
      if (q_head.posy[32:16] >= {8'd0, cfg.h}) begin
         y0_in = hm1;
         fy_in = 8'd0;
      end else begin
         y0_in = q_head.posy[23:16];
         fy_in = q_head.posy[15:8];
      end
      x1_in = (x0_in == wm1) ? wm1 : x0_in + 8'd1;
      y1_in = (y0_in == hm1) ? hm1 : y0_in + 8'd1;
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff <= q_head.cmd;
      s1_x0_ff  <= x0_in;
      s1_x1_ff  <= x1_in;
      s1_y0_ff  <= y0_in;
      s1_y1_ff  <= y1_in;
      s1_fx_ff  <= fx_in;
      s1_fy_ff  <= fy_in;
      s1_cx_ff  <= q_head.cx;
      s1_cy_ff  <= q_head.cy;
      s1_pix_ff <= q_head.pix;
   end

   // Bank {by,bx} holds the pixels whose row and column parities are by, bx.
   // The four neighbors always fall in distinct banks unless clamped to the
   // same pixel, so one read port per bank is enough.
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0]  mem [16384];
      logic [7:0]  col, row;
      logic [13:0] raddr, waddr;
      logic        we;

      always_comb begin
         col   = (s1_x0_ff[0] == b[0]) ? s1_x0_ff : s1_x1_ff;
         row   = (s1_y0_ff[0] == b[1]) ? s1_y0_ff : s1_y1_ff;
         raddr = {row[7:1], col[7:1]};
         waddr = {s1_cy_ff[7:1], s1_cx_ff[7:1]};
         we    = s1_v_ff && (s1_cmd_ff == irb_pkg::CMD_LOAD) &&
                 (s1_cx_ff[0] == b[0]) && (s1_cy_ff[0] == b[1]);
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem[waddr] <= s1_pix_ff;
         end
         rd_ff[b] <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      s2_par_ff[0] <= {s1_y0_ff[0], s1_x0_ff[0]};
      s2_par_ff[1] <= {s1_y0_ff[0], s1_x1_ff[0]};
      s2_par_ff[2] <= {s1_y1_ff[0], s1_x0_ff[0]};
      s2_par_ff[3] <= {s1_y1_ff[0], s1_x1_ff[0]};
      s2_fx_ff     <= s1_fx_ff;
      s2_fy_ff     <= s1_fy_ff;
      s2_cx_ff     <= s1_cx_ff;
      s2_cy_ff     <= s1_cy_ff;
   end

   logic [7:0]  p00, p10, p01, p11;
   logic [8:0]  wfx, wfy;
   logic [25:0] blend;

   always_comb begin
      p00   = rd_ff[s2_par_ff[0]];
      p10   = rd_ff[s2_par_ff[1]];
      p01   = rd_ff[s2_par_ff[2]];
      p11   = rd_ff[s2_par_ff[3]];
      wfx   = 9'd256 - {1'b0, s2_fx_ff};
      wfy   = 9'd256 - {1'b0, s3_fy_ff};
      blend = 26'(s3_top_ff * wfy) + 26'(s3_bot_ff * {1'b0, s3_fy_ff});
   end

   always_ff @(posedge clock) begin
      s3_top_ff  <= 17'(p00 * wfx) + 17'(p10 * {1'b0, s2_fx_ff});
      s3_bot_ff  <= 17'(p01 * wfx) + 17'(p11 * {1'b0, s2_fx_ff});
      s3_near_ff <= p00;
      s3_fy_ff   <= s2_fy_ff;
      s3_cx_ff   <= s2_cx_ff;
      s3_cy_ff   <= s2_cy_ff;
      s4_pix_ff  <= (cfg.mode == irb_pkg::MODE_NEAREST) ? s3_near_ff : blend[23:16];
      s4_cx_ff   <= s3_cx_ff;
      s4_cy_ff   <= s3_cy_ff;
      if (s4_v_ff) begin
         o_ff[owr_ff] <= {s4_pix_ff, s4_cx_ff, s4_cy_ff};
      end
   end

   assign rsp_empty = (ocnt_ff == 4'd0);
   assign opop      = rsp_pop && !rsp_empty;
   assign {rsp_pixel_out, rsp_out_x, rsp_out_y} = o_ff[ord_ff];
   assign ocnt_in   = ocnt_ff + 4'(s4_v_ff) - 4'(opop);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         s1_v_ff <= q_pop;
         s2_v_ff <= s1_v_ff && (s1_cmd_ff == irb_pkg::CMD_COMPUTE);
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         owr_ff  <= s4_v_ff ? owr_ff + 3'd1 : owr_ff;
         ord_ff  <= opop ? ord_ff + 3'd1 : ord_ff;
         ocnt_ff <= ocnt_in;
      end
   end

endmodule

/* rtl/core/image_resize_bilinear_nearest.sv */
// Grayscale image resizer, nearest or bilinear, with a 256x256 frame store.
// Throughput: one request per cycle, loads and computes alike, while the result queue has room.
// Once accepted, a compute request passes through index clamp, bank read, horizontal blend,
// vertical blend and the result queue before its result is on the result ports.
// Synchronous active-high reset empties both queues and restores the registers;
// the frame store is not cleared.
module image_resize_bilinear_nearest (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_coord_x,
   input  logic [7:0]  req_coord_y,
   input  logic [7:0]  req_pixel_in,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_pixel_out,
   output logic [7:0]  rsp_out_x,
   output logic [7:0]  rsp_out_y,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);

   logic [8:0]  width_ff, height_ff;
   logic [24:0] x_step_ff, y_step_ff;
   logic        mode_ff;
   irb_pkg::cfg_type   cfg;
   irb_pkg::qitem_type q_head;
   irb_pkg::stat_type  stat;
   logic q_empty, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         x_step_ff <= 25'd65536;
         y_step_ff <= 25'd65536;
         mode_ff   <= irb_pkg::MODE_BILINEAR;
      end else if (csr_we) begin
         unique case (csr_index)
            irb_pkg::CSR_SRC_WIDTH:  width_ff  <= csr_wdata[8:0];
            irb_pkg::CSR_SRC_HEIGHT: height_ff <= csr_wdata[8:0];
            irb_pkg::CSR_X_STEP:     x_step_ff <= csr_wdata;
            irb_pkg::CSR_Y_STEP:     y_step_ff <= csr_wdata;
            irb_pkg::CSR_MODE:       mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective size is clamped to 1..256.
   always_comb begin
      cfg.w    = (width_ff == 9'd0) ? 9'd1 :
                 (width_ff > 9'(irb_pkg::MAX_SIZE)) ? 9'(irb_pkg::MAX_SIZE) : width_ff;
      cfg.h    = (height_ff == 9'd0) ? 9'd1 :
                 (height_ff > 9'(irb_pkg::MAX_SIZE)) ? 9'(irb_pkg::MAX_SIZE) : height_ff;
      cfg.mode = mode_ff;
   end

   irb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (push),
      .req_full     (full),
      .req_cmd      (req_cmd),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_pixel_in (req_pixel_in),
      .x_step       (x_step_ff),
      .y_step       (y_step_ff),
      .q_pop        (q_pop),
      .q_empty      (q_empty),
      .q_head       (q_head)
   );

   irb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .stat          (stat)
   );

   // The result queue can never be overrun by work already in flight.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, stat.inflight} + stat.ocount <= 4'(irb_pkg::ODEPTH)))
      else $error("result queue overrun possible");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      empty == (stat.ocount == 4'd0))
      else $error("empty flag disagrees with result count");

   a_no_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !q_pop)
      else $error("back end took a request from an empty queue");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (empty && !full && stat.inflight == 3'd0))
      else $error("queues not empty after reset");

endmodule

/* tb/sv/irb_scoreboard.sv */
`timescale 1ns / 100ps
// Scoreboard for the image resizer testbench: a copy of the frame store,
// the resize predictor and the queue of expected pixels. Depends on irb_pkg.
class irb_scoreboard;
   typedef struct {
      logic [7:0] pixel;
      logic [7:0] x;
      logic [7:0] y;
   } pixel_rec_type;

   logic [7:0]    frame [65536];
   bit            written [65536];
   logic [8:0]    width_reg;
   logic [8:0]    height_reg;
   logic [24:0]   xstep_reg;
   logic [24:0]   ystep_reg;
   logic          mode_reg;
   pixel_rec_type expected_pixels [$];
   int            mismatches;
   int            results_seen;

   function new();
      width_reg   = 9'd256;
      height_reg  = 9'd256;
      xstep_reg   = 25'h10000;
      ystep_reg   = 25'h10000;
      mode_reg    = irb_pkg::MODE_BILINEAR;
      mismatches  = 0;
      results_seen = 0;
   endfunction

   function void write_register(logic [2:0] idx, logic [24:0] value);
      case (idx)
         irb_pkg::CSR_SRC_WIDTH:  width_reg  = value[8:0];
         irb_pkg::CSR_SRC_HEIGHT: height_reg = value[8:0];
         irb_pkg::CSR_X_STEP:     xstep_reg  = value;
         irb_pkg::CSR_Y_STEP:     ystep_reg  = value;
         irb_pkg::CSR_MODE:       mode_reg   = value[0];
         default: ;
      endcase
   endfunction

   function int eff_size(logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   // Source index and 8-bit weight for one axis; positions past the edge
   // saturate to the last index with zero weight.
   function void map_axis(logic [7:0] c, logic [24:0] step, int size,
                          output int idx, output int frac);
      logic [32:0] pos;
      pos = 33'(c) * 33'(step);
      if (pos[32:16] >= size) begin
         idx  = size - 1;
         frac = 0;
      end else begin
         idx  = pos[32:16];
         frac = pos[15:8];
      end
   endfunction

   function logic [7:0] pix_at(int x, int y);
      return frame[y * 256 + x];
   endfunction

   function logic [7:0] resize_pixel(logic [7:0] cx, logic [7:0] cy);
      int w, h, x0, y0, x1, y1, fx, fy;
      int unsigned top, bot;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      map_axis(cx, xstep_reg, w, x0, fx);
      map_axis(cy, ystep_reg, h, y0, fy);
      if (mode_reg == irb_pkg::MODE_NEAREST) return pix_at(x0, y0);
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      top = pix_at(x0, y0) * (256 - fx) + pix_at(x1, y0) * fx;
      bot = pix_at(x0, y1) * (256 - fx) + pix_at(x1, y1) * fx;
      return 8'((top * (256 - fy) + bot * fy) >> 16);
   endfunction

   function void note_request(logic cmd, logic [7:0] x, logic [7:0] y, logic [7:0] pix);
      pixel_rec_type r;
      if (cmd == irb_pkg::CMD_LOAD) begin
         frame[{y, x}]   = pix;
         written[{y, x}] = 1;
      end else begin
         r.pixel = resize_pixel(x, y);
         r.x = x;
         r.y = y;
         expected_pixels.push_back(r);
      end
   endfunction

   function void check_result(logic [7:0] pixel, logic [7:0] x, logic [7:0] y);
      pixel_rec_type r;
      results_seen++;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected result pixel=%0d x=%0d y=%0d", pixel, x, y);
         return;
      end
      r = expected_pixels.pop_front();
      if (pixel !== r.pixel || x !== r.x || y !== r.y) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: expected pixel=%0d x=%0d y=%0d, got pixel=%0d x=%0d y=%0d",
                     r.pixel, r.x, r.y, pixel, x, y);
      end
   endfunction
endclass

/* tb/sv/image_resize_bilinear_nearest_tb.sv */
`timescale 1ns / 100ps
// Top-level testbench for image_resize_bilinear_nearest: drives loads,
// computes and register writes and checks every result. Needs irb_pkg,
// irb_scoreboard and the RTL.
module image_resize_bilinear_nearest_tb;

   localparam int STALL_LIMIT = 2000;

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic        full;
   logic        req_cmd = 0;
   logic [7:0]  req_coord_x = 0;
   logic [7:0]  req_coord_y = 0;
   logic [7:0]  req_pixel_in = 0;
   logic        empty;
   logic        pop = 0;
   logic [7:0]  rsp_pixel_out;
   logic [7:0]  rsp_out_x;
   logic [7:0]  rsp_out_y;
   logic        csr_we = 0;
   logic [2:0]  csr_index = 0;
   logic [24:0] csr_wdata = 0;

   irb_scoreboard sb = new();
   int  requests_sent = 0;
   int  phases_run = 0;
   int  idle_cycles = 0;
   bit  req_burst = 0;
   bit  rsp_burst = 0;

   image_resize_bilinear_nearest DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic send_request(logic cmd, logic [7:0] x, logic [7:0] y, logic [7:0] pix);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         push <= 0;
         @(posedge clock);
      end
      push         <= 1;
      req_cmd      <= cmd;
      req_coord_x  <= x;
      req_coord_y  <= y;
      req_pixel_in <= pix;
      do @(posedge clock); while (full);
      sb.note_request(cmd, x, y, pix);
      requests_sent++;
      if ($urandom_range(0, 40) == 0) req_burst = !req_burst;
   endtask

   // The caller drops the write enable after its last register write.
   task automatic write_csr(logic [2:0] idx, logic [24:0] value);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(idx, value);
   endtask

   // Drain every expected pixel, then allow for loads still in the pipeline.
   task automatic wait_idle();
      push <= 0;
      @(posedge clock);
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Every entry that a compute can read under the current sizes gets written.
   task automatic fill_source();
      int w, h;
      w = sb.eff_size(sb.width_reg);
      h = sb.eff_size(sb.height_reg);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++)
            if (!sb.written[y * 256 + x] || $urandom_range(0, 7) == 0)
               send_request(irb_pkg::CMD_LOAD, 8'(x), 8'(y), 8'($urandom));
   endtask

   task automatic run_phase(logic [8:0] w, logic [8:0] h, logic [24:0] xs, logic [24:0] ys,
                            logic mode, int computes);
      int dx, dy;
      wait_idle();
      write_csr(irb_pkg::CSR_SRC_WIDTH, 25'(w));
      write_csr(irb_pkg::CSR_SRC_HEIGHT, 25'(h));
      write_csr(irb_pkg::CSR_X_STEP, xs);
      write_csr(irb_pkg::CSR_Y_STEP, ys);
      write_csr(irb_pkg::CSR_MODE, 25'(mode));
      csr_we <= 0;
      fill_source();
      // Keep most destination coordinates where the mapping lands inside the image.
      dx = (xs == 0) ? 256 : ((sb.eff_size(w) << 16) / xs) + 2;
      dy = (ys == 0) ? 256 : ((sb.eff_size(h) << 16) / ys) + 2;
      if (dx > 255) dx = 255;
      if (dy > 255) dy = 255;
      for (int i = 0; i < computes; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_request(irb_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
         else if ($urandom_range(0, 3) == 0)
            send_request(irb_pkg::CMD_COMPUTE, 8'($urandom), 8'($urandom), 8'($urandom));
         else
            send_request(irb_pkg::CMD_COMPUTE, 8'($urandom_range(0, dx)),
                         8'($urandom_range(0, dy)), 8'($urandom));
      end
      phases_run++;
   endtask

   // Result side: random pop gaps with occasional stretches of none.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 10);
         repeat (gap) begin
            pop <= 0;
            @(posedge clock);
         end
         pop <= 1;
         do @(posedge clock); while (empty);
         sb.check_result(rsp_pixel_out, rsp_out_x, rsp_out_y);
         if ($urandom_range(0, 40) == 0) rsp_burst = !rsp_burst;
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("image_resize_bilinear_nearest regression: fail");
         $finish;
      end
   end

   initial begin
      logic [8:0] w, h;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: corner loads, tiny and full-size images, zero and maximal steps.
      send_request(irb_pkg::CMD_LOAD, 8'd255, 8'd255, 8'd255);
      send_request(irb_pkg::CMD_LOAD, 8'd0, 8'd255, 8'd0);
      run_phase(9'd1, 9'd1, 25'h10000, 25'h10000, irb_pkg::MODE_BILINEAR, 3);
      run_phase(9'd2, 9'd2, 25'h08000, 25'h08000, irb_pkg::MODE_BILINEAR, 4);
      send_request(irb_pkg::CMD_COMPUTE, 8'd255, 8'd255, 8'd0);
      send_request(irb_pkg::CMD_COMPUTE, 8'd0, 8'd0, 8'd255);
      run_phase(9'd3, 9'd2, 25'd0, 25'h1FFFFFF, irb_pkg::MODE_NEAREST, 3);
      send_request(irb_pkg::CMD_COMPUTE, 8'd255, 8'd255, 8'd0);
      run_phase(9'd256, 9'd1, 25'd1, 25'h1000000, irb_pkg::MODE_BILINEAR, 4);
      send_request(irb_pkg::CMD_COMPUTE, 8'd255, 8'd0, 8'd0);
      run_phase(9'd0, 9'd300, 25'h0C000, 25'h0FF00, irb_pkg::MODE_BILINEAR, 4);
      send_request(irb_pkg::CMD_COMPUTE, 8'd0, 8'd255, 8'd0);
      run_phase(9'd511, 9'd0, 25'h1FFFFFF, 25'd0, irb_pkg::MODE_NEAREST, 3);

      while (requests_sent < 1800) begin
         w = 9'($urandom_range(1, 12));
         h = 9'($urandom_range(1, 12));
         run_phase(w, h,
                   ($urandom_range(0, 5) == 0) ? 25'($urandom) :
                      25'(($urandom_range(1, 4) * 32'h10000 + $urandom_range(0, 65535)) / 3),
                   ($urandom_range(0, 5) == 0) ? 25'($urandom) :
                      25'(($urandom_range(1, 4) * 32'h10000 + $urandom_range(0, 65535)) / 3),
                   1'($urandom), 90);
      end

      wait_idle();
      $display("Ran %0d requests over %0d register settings, %0d results checked,",
               requests_sent, phases_run, sb.results_seen);
      $display("bilinear and nearest modes, steps from zero to full scale, %0d mismatches.",
               sb.mismatches);
      if (sb.mismatches == 0)
         $display("image_resize_bilinear_nearest regression: pass");
      else
         $display("image_resize_bilinear_nearest regression: fail");
      $finish;
   end
endmodule

/* sim.f */
rtl/core/irb_pkg.sv
rtl/core/irb_front.sv
rtl/core/irb_back.sv
rtl/core/image_resize_bilinear_nearest.sv
tb/sv/irb_scoreboard.sv
tb/sv/image_resize_bilinear_nearest_tb.sv
